// ===== hw/rtl/wns_pkg.sv =====
// shared types, register indexes and constants of the wind noise shaper
`timescale 1ns / 1ps
`default_nettype none

package wns_pkg;

  // field and register widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CoeffW    = 16;
  localparam int unsigned StepW     = 32;
  localparam int unsigned GainW     = 15;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // internal widths of the gust path
  localparam int unsigned UW         = 17;  // quarter-wave argument, 0 to 65536
  localparam int unsigned PolyW      = 31;  // horner partial sum, q2.30
  localparam int unsigned GainModW   = 17;  // gust gain in units of 2^-17
  localparam int unsigned GustScaleW = 32;  // gust gain times output gain

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_FILTER_COEFF = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GUST_STEP    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OUTPUT_GAIN  = 2'd2;

  // register reset values
  localparam logic [CoeffW-1:0] FILTER_COEFF_RST = 16'd2949;
  localparam logic [StepW-1:0]  GUST_STEP_RST    = 32'd68174;
  localparam logic [GainW-1:0]  OUTPUT_GAIN_RST  = 15'd12000;

  // odd sine polynomial of the quarter wave, q2.30
  localparam logic [PolyW-1:0] SIN_C1 = 31'd1686629713;
  localparam logic [PolyW-1:0] SIN_C3 = 31'd693598668;
  localparam logic [PolyW-1:0] SIN_C5 = 31'd85569306;
  localparam logic [PolyW-1:0] SIN_C7 = 31'd5026995;

  // 0.75 in units of 2^-17
  localparam logic [GainModW-1:0] GUST_BIAS = 17'd98304;

  // datapath step, one multiply each
  typedef enum logic [3:0] {
    OP_NONE,
    OP_IDX,
    OP_FRAC,
    OP_USQ,
    OP_POLY5,
    OP_POLY3,
    OP_POLY1,
    OP_SINE,
    OP_GGAIN,
    OP_STAGE1,
    OP_STAGE2,
    OP_OUT
  } wns_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX,
    ST_FRAC,
    ST_USQ,
    ST_POLY5,
    ST_POLY3,
    ST_POLY1,
    ST_SINE,
    ST_GGAIN,
    ST_STAGE1,
    ST_STAGE2,
    ST_OUT
  } wns_state_e;

  typedef struct packed {
    logic    take;      // input beat accepted this cycle
    wns_op_e op;        // datapath step
    logic    out_load;  // load the output register
  } wns_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wind_noise_shaper_top.sv =====
// top level of the wind noise shaper: stream ports, configuration port, sequencer and datapath
//
// usage
//   white noise comes in on the slave stream, one q1.15 sample per beat, and
//   shaped wind noise leaves on the master stream, one pcm sample per beat.
//   every input beat gives exactly one output beat, in order.
//   the configuration port writes filter_coeff (index 0), gust_step (index 1)
//   and output_gain (index 2) with no wait; other indexes are ignored.
//   write it only while no sample is in flight.
// steps
//   a sample takes 11 steps of the one shared multiplier (gust index, angle,
//   four horner steps, sine rounding, gain product, two filter stages and the
//   output product); the output beat is offered once the output register is
//   loaded in the last step, and no new input beat is taken until that step ends
// reset
//   both filter stages and the gust phase clear to zero and the registers
//   return to their defaults; no beat is offered until the first sample is done
// back-pressure
//   the output register decouples the two sides: the next sample is taken and
//   worked on while a result waits; it then holds in its last step until the
//   waiting beat is claimed
`timescale 1ns / 1ps
`default_nettype none

module wind_noise_shaper_top #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned STATE_FRAC_BITS  = 23
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [wns_pkg::SampleW-1:0]   s_axis_tdata,   // [15:0] noise_sample
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [wns_pkg::SampleW-1:0]        m_axis_tdata,   // [15:0] wind_sample
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [wns_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [wns_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import wns_pkg::*;

  wns_cmd_t                  cmd;
  logic signed [SampleW-1:0] wind;

  // sequencer: one step per cycle, holding in the last step while a beat is unclaimed; owns the beat handshakes
  wns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // datapath: filter state, gust phase, sine polynomial and output scaling
  wns_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .STATE_FRAC_BITS  (STATE_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .noise_i     (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wind_o      (wind)
  );

  assign m_axis_tdata = wind;

endmodule

`default_nettype wire

// ===== hw/rtl/wns_ctrl.sv =====
// sequencer of the wind noise shaper: steps the datapath and owns the output valid
`timescale 1ns / 1ps
`default_nettype none

module wns_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output wns_pkg::wns_cmd_t    cmd_o
);
  import wns_pkg::*;

  wns_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.take      = 1'b0;
    cmd_o.op        = OP_NONE;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_IDX;
        end
      end
      ST_IDX: begin
        cmd_o.op = OP_IDX;
        state_d  = ST_FRAC;
      end
      ST_FRAC: begin
        cmd_o.op = OP_FRAC;
        state_d  = ST_USQ;
      end
      ST_USQ: begin
        cmd_o.op = OP_USQ;
        state_d  = ST_POLY5;
      end
      ST_POLY5: begin
        cmd_o.op = OP_POLY5;
        state_d  = ST_POLY3;
      end
      ST_POLY3: begin
        cmd_o.op = OP_POLY3;
        state_d  = ST_POLY1;
      end
      ST_POLY1: begin
        cmd_o.op = OP_POLY1;
        state_d  = ST_SINE;
      end
      ST_SINE: begin
        cmd_o.op = OP_SINE;
        state_d  = ST_GGAIN;
      end
      ST_GGAIN: begin
        cmd_o.op = OP_GGAIN;
        state_d  = ST_STAGE1;
      end
      ST_STAGE1: begin
        cmd_o.op = OP_STAGE1;
        state_d  = ST_STAGE2;
      end
      ST_STAGE2: begin
        cmd_o.op = OP_STAGE2;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.op = OP_OUT;
        // wait here while the previous beat is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_shows_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("output register loaded but no beat offered");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_IDX))
    else $error("accepted beat did not start the sequence");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("finished sample left the last step while output was stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/wns_datapath.sv =====
// datapath of the wind noise shaper: registers, shared multiplier and step logic
`timescale 1ns / 1ps
`default_nettype none

module wns_datapath #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned STATE_FRAC_BITS  = 23
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire wns_pkg::wns_cmd_t                 cmd_i,
  input  wire logic signed [wns_pkg::SampleW-1:0] noise_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [wns_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [wns_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output logic signed [wns_pkg::SampleW-1:0]     wind_o
);
  import wns_pkg::*;

  localparam int unsigned F   = STATE_FRAC_BITS;
  localparam int unsigned SW  = F + 1;          // stage state width
  localparam int unsigned DW  = F + 2;          // stage difference width
  localparam int unsigned MA  = (DW > 33) ? DW : 33;
  localparam int unsigned MB  = 33;
  localparam int unsigned PW  = MA + MB;
  localparam int unsigned IW  = $clog2(SINE_TABLE_DEPTH);
  // table index to 18-bit angle: idx * 2^18 / depth by reciprocal
  localparam int unsigned RecipK    = 30 + IW;
  localparam logic [63:0] RECIP     =
    ((64'd1 << RecipK) + SINE_TABLE_DEPTH - 1) / SINE_TABLE_DEPTH;
  localparam int unsigned FracShift = RecipK - 18;

  localparam logic signed [SW-1:0] ST_MAX = {1'b0, {F{1'b1}}};
  localparam logic signed [SW-1:0] ST_MIN = {1'b1, {F{1'b0}}};

  // configuration
  logic [CoeffW-1:0] coeff_q;
  logic [StepW-1:0]  step_q;
  logic [GainW-1:0]  gain_q;

  // filter and phase state
  logic signed [SW-1:0] s1_q, s2_q;
  logic [StepW-1:0]     phase_q;

  // per-sample working registers
  logic signed [SampleW-1:0] noise_q;
  logic [IW-1:0]             idx_q;
  logic [UW-1:0]             u_q;
  logic                      sneg_q;
  logic [UW-1:0]             u2_q;
  logic [PolyW-1:0]          p_q;
  logic [GainModW-1:0]       g_q;
  logic [GustScaleW-1:0]     gg_q;
  logic [SampleW-1:0]        wind_q;

  logic signed [SW-1:0] x;
  logic signed [DW-1:0] diff1, diff2;
  logic [SW-1:0]        mag;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;

  assign x     = SW'(noise_q) <<< (F - 15);
  assign diff1 = DW'(x) - DW'(s1_q);
  assign diff2 = DW'(s1_q) - DW'(s2_q);
  assign mag   = s2_q[SW-1] ? SW'(-s2_q) : SW'(s2_q);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_IDX: begin
        mul_a = MA'(phase_q);
        mul_b = MB'(SINE_TABLE_DEPTH);
      end
      OP_FRAC: begin
        mul_a = MA'(RECIP);
        mul_b = MB'(idx_q);
      end
      OP_USQ: begin
        mul_a = MA'(u_q);
        mul_b = MB'(u_q);
      end
      OP_POLY5: begin
        mul_a = MA'(SIN_C7);
        mul_b = MB'(u2_q);
      end
      OP_POLY3, OP_POLY1: begin
        mul_a = MA'(p_q);
        mul_b = MB'(u2_q);
      end
      OP_SINE: begin
        mul_a = MA'(p_q);
        mul_b = MB'(u_q);
      end
      OP_GGAIN: begin
        mul_a = MA'(g_q);
        mul_b = MB'(gain_q);
      end
      OP_STAGE1: begin
        mul_a = MA'(diff1);
        mul_b = MB'(coeff_q);
      end
      OP_STAGE2: begin
        mul_a = MA'(diff2);
        mul_b = MB'(coeff_q);
      end
      OP_OUT: begin
        mul_a = MA'(mag);
        mul_b = MB'(gg_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // step post-processing
  logic [17:0]          frac;
  logic [UW-1:0]        u_d;
  logic [31:0]          horner;
  logic [PolyW-1:0]     p_d;
  logic [32:0]          sine_rnd;
  logic [14:0]          sine_v;
  logic [GainModW-1:0]  g_d;
  logic signed [SW-1:0] stage_cur, stage_new;
  logic signed [PW-1:0] step_v, sum_v;
  logic [16:0]          out_q17;
  logic [SampleW-1:0]   wind_d;

  always_comb begin
    frac = prod[FracShift +: 18];
    if (frac[16]) begin
      u_d = 17'd65536 - {1'b0, frac[15:0]};
    end else begin
      u_d = {1'b0, frac[15:0]};
    end

    horner = prod[47:16];
    case (cmd_i.op)
      OP_POLY5: p_d = PolyW'(32'(SIN_C5) - horner);
      OP_POLY3: p_d = PolyW'(32'(SIN_C3) - horner);
      default:  p_d = PolyW'(32'(SIN_C1) - horner);
    endcase

    // round q2.30 product to q1.15, cap at 32767
    sine_rnd = (33'(prod[47:16]) + 33'd16384) >> 15;
    sine_v   = (sine_rnd > 33'd32767) ? 15'd32767 : sine_rnd[14:0];
    g_d      = sneg_q ? (GUST_BIAS - GainModW'(sine_v)) : (GUST_BIAS + GainModW'(sine_v));

    // one-pole update with round-half-up and clamp
    stage_cur = (cmd_i.op == OP_STAGE2) ? s2_q : s1_q;
    step_v    = (prod + PW'(32768)) >>> 16;
    sum_v     = PW'(stage_cur) + step_v;
    if (sum_v > PW'(ST_MAX)) begin
      stage_new = ST_MAX;
    end else if (sum_v < PW'(ST_MIN)) begin
      stage_new = ST_MIN;
    end else begin
      stage_new = sum_v[SW-1:0];
    end

    // truncate magnitude, restore sign, saturate
    out_q17 = prod[F + 17 +: 17];
    if (s2_q[SW-1]) begin
      wind_d = (out_q17 > 17'd32768) ? 16'h8000 : SampleW'(~out_q17 + 17'd1);
    end else begin
      wind_d = (out_q17 > 17'd32767) ? 16'h7fff : out_q17[15:0];
    end
  end

  // configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= FILTER_COEFF_RST;
      step_q  <= GUST_STEP_RST;
      gain_q  <= OUTPUT_GAIN_RST;
      s1_q    <= '0;
      s2_q    <= '0;
      phase_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FILTER_COEFF: coeff_q <= cfg_wdata_i[CoeffW-1:0];
          REG_GUST_STEP:    step_q  <= cfg_wdata_i[StepW-1:0];
          REG_OUTPUT_GAIN:  gain_q  <= cfg_wdata_i[GainW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        phase_q <= phase_q + step_q;
      end
      if (cmd_i.op == OP_STAGE1) begin
        s1_q <= stage_new;
      end
      if (cmd_i.op == OP_STAGE2) begin
        s2_q <= stage_new;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      noise_q <= noise_i;
    end
    if (cmd_i.out_load) begin
      wind_q <= wind_d;
    end
    case (cmd_i.op)
      OP_IDX: idx_q <= prod[32 +: IW];
      OP_FRAC: begin
        u_q    <= u_d;
        sneg_q <= frac[17];
      end
      OP_USQ:                      u2_q <= prod[16 +: UW];
      OP_POLY5, OP_POLY3, OP_POLY1: p_q  <= p_d;
      OP_SINE:                     g_q  <= g_d;
      OP_GGAIN:                    gg_q <= prod[GustScaleW-1:0];
      default: ;
    endcase
  end

  assign wind_o = wind_q;

  a_quarter_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.op == OP_FRAC) |-> (u_q <= 17'd65536))
    else $error("quarter-wave argument out of range");

  a_gust_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.op == OP_SINE) |-> (g_q >= 17'd65537))
    else $error("gust gain below 0.5");

  a_zero_coeff_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_STAGE1 && coeff_q == '0 && !cfg_we_i) |=> (s1_q == $past(s1_q)))
    else $error("first stage moved with a zero coefficient");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench of the wind noise shaper: directed table, then random beats with gaps
`timescale 1ns / 1ps

module tb;
  import wns_pkg::*;

  localparam int unsigned SineDepth  = 1024;
  localparam int unsigned FracBits   = 23;
  localparam int unsigned StallLimit = 2000;  // cycles with no beat on either side
  localparam int unsigned TailCycles = 24;    // settle time after the last beat
  localparam int unsigned MaxReports = 10;
  localparam int unsigned SegItems   = 92;    // beats per random configuration

  // index past the register list, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_NOISE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;   // register value, or the noise sample in the low bits
    logic                fixed;  // wind holds the expected sample
    logic [SampleW-1:0]  wind;
  } plan_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SampleW-1:0]  m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  // predictor state and registers
  int                  sine_rom [SineDepth];
  logic [CoeffW-1:0]   coeff_q;
  logic [StepW-1:0]    gust_step_q;
  logic [GainW-1:0]    gain_q;
  longint              stage_a;
  longint              stage_b;
  logic [31:0]         phase_q;

  logic [SampleW-1:0]  wind_due [$];
  int unsigned         bad_beats     = 0;
  int unsigned         stall_cycles  = 0;
  int unsigned         src_idle_pct  = 0;
  int unsigned         sink_idle_pct = 0;

  wind_noise_shaper_top #(
    .SINE_TABLE_DEPTH(SineDepth),
    .STATE_FRAC_BITS (FracBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [15:0] noise_sample
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [15:0] wind_sample
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // quarter-wave sine in q1.15 from the odd horner polynomial, u in 0..65536
  function automatic int quarter_wave(longint u);
    longint u2, p, s;
    u2 = (u * u) >>> 16;
    p  = longint'(SIN_C7);
    p  = longint'(SIN_C5) - ((p * u2) >>> 16);
    p  = longint'(SIN_C3) - ((p * u2) >>> 16);
    p  = longint'(SIN_C1) - ((p * u2) >>> 16);
    s  = (p * u) >>> 16;
    s  = (s + 16384) >>> 15;
    if (s > 32767) s = 32767;
    if (s < 0) s = 0;
    return int'(s);
  endfunction

  function automatic void build_sine_rom();
    longint unsigned f, quad;
    longint r, u;
    int v;
    for (int i = 0; i < SineDepth; i++) begin
      f    = (longint'(i) << 18) / SineDepth;
      quad = (f >> 16) & 3;
      r    = longint'(f & 64'hFFFF);
      u    = quad[0] ? 65536 - r : r;
      v    = quarter_wave(u);
      sine_rom[i] = (quad >= 2) ? -v : v;
    end
  endfunction

  // one-pole step with round-half-up, clamped to the state range
  function automatic longint smooth(longint s, longint x);
    longint top, nxt;
    top = longint'(1) << FracBits;
    nxt = s + (((x - s) * longint'(coeff_q) + 32768) >>> 16);
    if (nxt > top - 1) nxt = top - 1;
    if (nxt < -top) nxt = -top;
    return nxt;
  endfunction

  // advances the predictor by one noise sample and gives the wind sample it yields
  function automatic logic [SampleW-1:0] shape_wind(logic [SampleW-1:0] noise);
    longint          x, idx, gain_mod;
    longint unsigned mag;
    logic [63:0]     wide;
    x       = longint'($signed(noise)) * (longint'(1) << (FracBits - 15));
    stage_a = smooth(stage_a, x);
    stage_b = smooth(stage_b, stage_a);
    phase_q = phase_q + gust_step_q;
    wide    = {32'd0, phase_q} * 64'(SineDepth);
    idx     = longint'(wide >> 32);
    if (idx >= SineDepth) idx = SineDepth - 1;
    gain_mod = longint'(GUST_BIAS) + longint'(sine_rom[idx]);
    mag      = (stage_b < 0) ? -stage_b : stage_b;
    mag      = (mag * gain_mod * gain_q) >> (FracBits + 17);
    if (stage_b < 0) begin
      if (mag > 32768) mag = 32768;
      return SampleW'(-longint'(mag));
    end
    if (mag > 32767) mag = 32767;
    return SampleW'(mag);
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_FILTER_COEFF: coeff_q     = data[CoeffW-1:0];
      REG_GUST_STEP:    gust_step_q = data[StepW-1:0];
      REG_OUTPUT_GAIN:  gain_q      = data[GainW-1:0];
      default: ;
    endcase
  endfunction

  function automatic plan_row_t noise_row(logic [SampleW-1:0] noise);
    return '{kind: ROW_NOISE, idx: '0, data: CfgDataW'(noise), fixed: 1'b0, wind: '0};
  endfunction

  function automatic plan_row_t known_row(logic [SampleW-1:0] noise, logic [SampleW-1:0] wind);
    return '{kind: ROW_NOISE, idx: '0, data: CfgDataW'(noise), fixed: 1'b1, wind: wind};
  endfunction

  function automatic plan_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    return '{kind: ROW_REG, idx: idx, data: data, fixed: 1'b0, wind: '0};
  endfunction

  // zero, all ones (masked to the register's top) or anything
  function automatic logic [CfgDataW-1:0] pick_reg_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SampleW-1:0] pick_noise();
    case ($urandom_range(7))
      0:       return {1'b0, {(SampleW-1){1'b1}}};
      1:       return {1'b1, {(SampleW-1){1'b0}}};
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic report_bad(input string what, input logic [SampleW-1:0] want,
                            input logic [SampleW-1:0] got);
    bad_beats++;
    if (bad_beats <= MaxReports)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // offers one noise beat after a random gap and logs what should come out
  task automatic send_noise(input logic [SampleW-1:0] noise, input logic fixed,
                            input logic [SampleW-1:0] wind);
    logic [SampleW-1:0] predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= noise;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = shape_wind(noise);
    wind_due.insert(wind_due.size(), fixed ? wind : predicted);
  endtask

  // holds the input side until every outstanding sample has left
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (wind_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // output side: check each beat against the oldest expectation, random back-pressure
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (wind_due.size() == 0) begin
        report_bad("beat with nothing expected", 'x, m_axis_tdata);
      end else begin
        if (m_axis_tdata !== wind_due[0])
          report_bad("wind_sample mismatch", wind_due[0], m_axis_tdata);
        void'(wind_due.pop_front());
      end
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    plan_row_t plan [$];

    build_sine_rom();
    coeff_q     = FILTER_COEFF_RST;
    gust_step_q = GUST_STEP_RST;
    gain_q      = OUTPUT_GAIN_RST;
    stage_a     = 0;
    stage_b     = 0;
    phase_q     = '0;

    plan = '{
      // silence straight after reset leaves both stages at zero
      known_row(16'h0000, 16'h0000),
      known_row(16'h0000, 16'h0000),
      // full-scale swings at the default settings
      noise_row(16'h7FFF),
      noise_row(16'h8000),
      noise_row(16'h7FFF),
      // out-of-list index must not disturb any register
      reg_row(REG_SPARE, 32'hFFFF_FFFF),
      noise_row(16'h8000),
      // coefficient near one, top gain, largest phase step
      reg_row(REG_FILTER_COEFF, 32'h0000_FFFF),
      reg_row(REG_OUTPUT_GAIN, 32'h0000_7FFF),
      reg_row(REG_GUST_STEP, 32'hFFFF_FFFF),
      noise_row(16'h8000),
      noise_row(16'h8000),
      noise_row(16'h8000),
      noise_row(16'h7FFF),
      noise_row(16'h7FFF),
      noise_row(16'h7FFF),
      // zero coefficient: stages hold, only the gust gain moves the output
      reg_row(REG_FILTER_COEFF, 32'h0000_0000),
      noise_row(16'h1234),
      noise_row(16'h0001),
      // zero gain silences everything
      reg_row(REG_OUTPUT_GAIN, 32'h0000_0000),
      known_row(16'h7FFF, 16'h0000),
      known_row(16'h8000, 16'h0000),
      // smallest nonzero coefficient and gain, frozen gust phase
      reg_row(REG_FILTER_COEFF, 32'h0000_0001),
      reg_row(REG_OUTPUT_GAIN, 32'h0000_0001),
      reg_row(REG_GUST_STEP, 32'h0000_0000),
      noise_row(16'h7FFF),
      noise_row(16'h8000),
      // back to the reset values
      reg_row(REG_FILTER_COEFF, 32'h0000_0B85),
      reg_row(REG_GUST_STEP, 32'h0001_0A4E),
      reg_row(REG_OUTPUT_GAIN, 32'h0000_2EE0),
      noise_row(16'h5A5A),
      noise_row(16'hA5A5),
      noise_row(16'h0000),
      noise_row(16'hFFFF)
    };

    src_idle_pct  = 12;
    sink_idle_pct = 55;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_noise(plan[i].data[SampleW-1:0], plan[i].fixed, plan[i].wind);
      end
    end

    // random part: slow receiver, then slow sender, then both flat out
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct  = (mode == 0) ? 12 : (mode == 1) ? 55 : 0;
      sink_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 12 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        write_reg(REG_FILTER_COEFF, pick_reg_value());
        write_reg(REG_GUST_STEP, pick_reg_value());
        write_reg(REG_OUTPUT_GAIN, pick_reg_value());
        if ($urandom_range(1) == 1) write_reg(REG_SPARE, $urandom);
        for (int n = 0; n < SegItems; n++) begin
          // now and then let the pipe run empty before the next beat
          if ($urandom_range(63) == 0) drain();
          send_noise(pick_noise(), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (bad_beats == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wns_pkg.sv
hw/rtl/wns_ctrl.sv
hw/rtl/wns_datapath.sv
hw/rtl/wind_noise_shaper_top.sv
test/tb.sv
